// ----- src/dttq_pkg.sv -----
// ----------------------------------------------------------------------------
// dttq_pkg
// Shared constants, request codes and cell command type of the delta-list
// timer queue.
// ----------------------------------------------------------------------------
package dttq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int DELAY_BITS_DEF   = 32;
  localparam int TASK_ID_BITS_DEF = 8;

  localparam int FUNC_W = 2;

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd2;

  // cell operations
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan;
  } cell_cmd_t;

endpackage

// ----- src/dttq_in_if.sv -----
// ----------------------------------------------------------------------------
// dttq_in_if
// Request channel of the timer queue: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface dttq_in_if #(
  parameter int DLY_W = dttq_pkg::DELAY_BITS_DEF,
  parameter int ID_W  = dttq_pkg::TASK_ID_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [dttq_pkg::FUNC_W-1:0]   func;
  logic [ID_W-1:0]               task_id;
  logic [DLY_W-1:0]              delay;
  logic [DLY_W-1:0]              period;

  modport source (output valid, func, task_id, delay, period, input ready);
  modport sink   (input valid, func, task_id, delay, period, output ready);
endinterface

// ----- src/dttq_out_if.sv -----
// ----------------------------------------------------------------------------
// dttq_out_if
// Result channel of the timer queue: valid/ready with the result payload.
// ----------------------------------------------------------------------------
interface dttq_out_if #(
  parameter int ID_W  = dttq_pkg::TASK_ID_BITS_DEF,
  parameter int CNT_W = $clog2(dttq_pkg::QUEUE_DEPTH_DEF + 1)
);
  logic             valid;
  logic             ready;
  logic             fired;
  logic [ID_W-1:0]  fired_task;
  logic             add_full;
  logic [CNT_W-1:0] add_position;
  logic [CNT_W-1:0] entry_total;

  modport source (output valid, fired, fired_task, add_full, add_position, entry_total,
                  input ready);
  modport sink   (input valid, fired, fired_task, add_full, add_position, entry_total,
                  output ready);
endinterface

// ----- src/dttq_cell.sv -----
// ----------------------------------------------------------------------------
// dttq_cell
// One queue slot: holds delta, period and task id, shifts to its neighbors on
// pop and insert, and carries one stage of the running-deadline scan.
// ----------------------------------------------------------------------------
module dttq_cell #(
  parameter int DLY_W    = dttq_pkg::DELAY_BITS_DEF,
  parameter int ID_W     = dttq_pkg::TASK_ID_BITS_DEF,
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  dttq_pkg::cell_cmd_t cmd,
  input  logic                live,
  input  logic [DLY_W-1:0]    key,
  input  logic [IDX_W-1:0]    ins_pos,
  input  logic [DLY_W-1:0]    ins_delta,
  input  logic [DLY_W-1:0]    ins_period,
  input  logic [ID_W-1:0]     ins_id,
  input  logic [DLY_W-1:0]    left_delta,
  input  logic [DLY_W-1:0]    left_period,
  input  logic [ID_W-1:0]     left_id,
  input  logic [DLY_W-1:0]    right_delta,
  input  logic [DLY_W-1:0]    right_period,
  input  logic [ID_W-1:0]     right_id,
  output logic [DLY_W-1:0]    delta_q,
  output logic [DLY_W-1:0]    period_q,
  output logic [ID_W-1:0]     id_q,
  input  logic [DLY_W-1:0]    cum_in,
  input  logic [DLY_W-1:0]    before_in,
  input  logic                found_in,
  input  logic [IDX_W-1:0]    pos_in,
  output logic [DLY_W-1:0]    cum_out,
  output logic [DLY_W-1:0]    before_out,
  output logic                found_out,
  output logic [IDX_W-1:0]    pos_out
);

  localparam logic [IDX_W:0]   ME     = (IDX_W+1)'(CELL_IDX);
  localparam logic [IDX_W-1:0] ME_POS = IDX_W'(CELL_IDX);

  logic [DLY_W-1:0] delta_r, delta_nxt;
  logic [DLY_W-1:0] period_r, period_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [DLY_W-1:0] cum_r, cum_nxt;
  logic [DLY_W-1:0] before_r, before_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W:0]   pos_x;
  logic [DLY_W-1:0] sum;

  assign pos_x = {1'b0, ins_pos};
  assign sum   = cum_in + delta_r;

  always_comb begin
    delta_nxt  = delta_r;
    period_nxt = period_r;
    id_nxt     = id_r;
    case (cmd.op)
      dttq_pkg::OP_TICK: begin
        if (CELL_IDX == 0 && delta_r != '0) begin
          delta_nxt = delta_r - DLY_W'(1);
        end
      end
      dttq_pkg::OP_POP: begin
        delta_nxt  = right_delta;
        period_nxt = right_period;
        id_nxt     = right_id;
      end
      dttq_pkg::OP_INSERT: begin
        if (ME > pos_x) begin
          delta_nxt  = left_delta;
          period_nxt = left_period;
          id_nxt     = left_id;
          if (ME == pos_x + (IDX_W+1)'(1)) begin
            delta_nxt = left_delta - ins_delta;
          end
        end else if (ME == pos_x) begin
          delta_nxt  = ins_delta;
          period_nxt = ins_period;
          id_nxt     = ins_id;
        end
      end
      default: begin
      end
    endcase
  end

  // advance the running deadline until the first later entry is found
  always_comb begin
    cum_nxt    = cum_r;
    before_nxt = before_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    if (cmd.scan) begin
      cum_nxt    = cum_in;
      before_nxt = before_in;
      found_nxt  = found_in;
      pos_nxt    = pos_in;
      if (!found_in && live) begin
        before_nxt = cum_in;
        cum_nxt    = sum;
        if (key < sum) begin
          found_nxt = 1'b1;
          pos_nxt   = ME_POS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    delta_r  <= delta_nxt;
    period_r <= period_nxt;
    id_r     <= id_nxt;
    cum_r    <= cum_nxt;
    before_r <= before_nxt;
    found_r  <= found_nxt;
    pos_r    <= pos_nxt;
  end

  assign delta_q    = delta_r;
  assign period_q   = period_r;
  assign id_q       = id_r;
  assign cum_out    = cum_r;
  assign before_out = before_r;
  assign found_out  = found_r;
  assign pos_out    = pos_r;

endmodule

// ----- src/delta_timer_task_queue.sv -----
// ----------------------------------------------------------------------------
// delta_timer_task_queue
// Bounded timer queue of tasks in deadline order, kept as delta delays.
// ----------------------------------------------------------------------------
// Requests arrive on in_chan (valid/ready); func selects tick, add or
// dispatch check. Each request yields exactly one result on out_chan.
// A tick counts the head delta down, an add inserts a task behind all
// entries with an equal or earlier deadline, a dispatch check fires an
// expired head, pops it and re-adds it when its period is nonzero.
// Tick, unknown, rejected add and dispatch without re-add go from the
// execute state straight to the done state. Accepted add and a dispatch
// that re-adds first run the deadline scan over the whole chain, which
// moves one cell of the chain per cycle, then a commit state that inserts
// the entry, before the done state. A new request is taken only when the
// previous one has finished its work.
// The result sits in an output register; while the receiver stalls the
// block already takes and works the next request and holds its result
// until the register frees. Reset empties the queue and clears out_valid;
// slot contents are left as they are.
// ----------------------------------------------------------------------------
module delta_timer_task_queue #(
  parameter int QUEUE_DEPTH  = dttq_pkg::QUEUE_DEPTH_DEF,
  parameter int DELAY_BITS   = dttq_pkg::DELAY_BITS_DEF,
  parameter int TASK_ID_BITS = dttq_pkg::TASK_ID_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dttq_in_if.sink   in_chan,
  dttq_out_if.source out_chan
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [dttq_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [TASK_ID_BITS-1:0] ins_id_r, ins_id_nxt;
  logic [DELAY_BITS-1:0]   ins_dly_r, ins_dly_nxt;
  logic [DELAY_BITS-1:0]   ins_per_r, ins_per_nxt;
  logic                    res_fired_r, res_fired_nxt;
  logic [TASK_ID_BITS-1:0] res_task_r, res_task_nxt;
  logic                    res_full_r, res_full_nxt;
  logic [CNT_W-1:0]        res_pos_r, res_pos_nxt;
  logic                    out_fired_r;
  logic [TASK_ID_BITS-1:0] out_task_r;
  logic                    out_full_r;
  logic [CNT_W-1:0]        out_pos_r;
  logic [CNT_W-1:0]        out_total_r;

  dttq_pkg::cell_cmd_t     cmd;
  logic                    accept;
  logic                    load_out;
  logic [IDX_W-1:0]        pos_f;
  logic [DELAY_BITS-1:0]   before_f;
  logic [DELAY_BITS-1:0]   nd;

  logic [DELAY_BITS-1:0]   c_delta  [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0]   c_period [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] c_id     [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0]   t_cum    [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0]   t_before [QUEUE_DEPTH];
  logic                    t_found  [QUEUE_DEPTH];
  logic [IDX_W-1:0]        t_pos    [QUEUE_DEPTH];

  assign accept   = in_chan.valid && in_chan.ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign pos_f    = t_found[QUEUE_DEPTH-1] ? t_pos[QUEUE_DEPTH-1] : count_r[IDX_W-1:0];
  assign before_f = t_found[QUEUE_DEPTH-1] ? t_before[QUEUE_DEPTH-1] : t_cum[QUEUE_DEPTH-1];
  assign nd       = ins_dly_r - before_f;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DELAY_BITS-1:0]   l_delta, l_period, r_delta, r_period;
    logic [TASK_ID_BITS-1:0] l_id, r_id;
    logic [DELAY_BITS-1:0]   cum_i, before_i;
    logic                    found_i;
    logic [IDX_W-1:0]        pos_i;

    if (i == 0) begin : g_head
      assign l_delta  = nd;
      assign l_period = ins_per_r;
      assign l_id     = ins_id_r;
      assign cum_i    = '0;
      assign before_i = '0;
      assign found_i  = 1'b0;
      assign pos_i    = '0;
    end else begin : g_body
      assign l_delta  = c_delta[i-1];
      assign l_period = c_period[i-1];
      assign l_id     = c_id[i-1];
      assign cum_i    = t_cum[i-1];
      assign before_i = t_before[i-1];
      assign found_i  = t_found[i-1];
      assign pos_i    = t_pos[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_delta  = c_delta[i];
      assign r_period = c_period[i];
      assign r_id     = c_id[i];
    end else begin : g_mid
      assign r_delta  = c_delta[i+1];
      assign r_period = c_period[i+1];
      assign r_id     = c_id[i+1];
    end

    dttq_cell #(
      .DLY_W    (DELAY_BITS),
      .ID_W     (TASK_ID_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .live         (CNT_W'(i) < count_r),
      .key          (ins_dly_r),
      .ins_pos      (pos_f),
      .ins_delta    (nd),
      .ins_period   (ins_per_r),
      .ins_id       (ins_id_r),
      .left_delta   (l_delta),
      .left_period  (l_period),
      .left_id      (l_id),
      .right_delta  (r_delta),
      .right_period (r_period),
      .right_id     (r_id),
      .delta_q      (c_delta[i]),
      .period_q     (c_period[i]),
      .id_q         (c_id[i]),
      .cum_in       (cum_i),
      .before_in    (before_i),
      .found_in     (found_i),
      .pos_in       (pos_i),
      .cum_out      (t_cum[i]),
      .before_out   (t_before[i]),
      .found_out    (t_found[i]),
      .pos_out      (t_pos[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    func_nxt      = func_r;
    ins_id_nxt    = ins_id_r;
    ins_dly_nxt   = ins_dly_r;
    ins_per_nxt   = ins_per_r;
    res_fired_nxt = res_fired_r;
    res_task_nxt  = res_task_r;
    res_full_nxt  = res_full_r;
    res_pos_nxt   = res_pos_r;
    cmd.op        = dttq_pkg::OP_HOLD;
    cmd.scan      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt      = in_chan.func;
          ins_id_nxt    = in_chan.task_id;
          ins_dly_nxt   = in_chan.delay;
          ins_per_nxt   = in_chan.period;
          res_fired_nxt = 1'b0;
          res_task_nxt  = '0;
          res_full_nxt  = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (func_r)
          dttq_pkg::FUNC_TICK: begin
            if (count_r != '0) begin
              cmd.op = dttq_pkg::OP_TICK;
            end
          end
          dttq_pkg::FUNC_ADD: begin
            if (count_r == CNT_FULL) begin
              res_full_nxt = 1'b1;
              res_pos_nxt  = CNT_FULL;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          dttq_pkg::FUNC_DISPATCH: begin
            if (count_r != '0 && c_delta[0] == '0) begin
              res_fired_nxt = 1'b1;
              res_task_nxt  = c_id[0];
              cmd.op        = dttq_pkg::OP_POP;
              count_nxt     = count_r - CNT_W'(1);
              ins_id_nxt    = c_id[0];
              ins_dly_nxt   = c_period[0];
              ins_per_nxt   = c_period[0];
              if (c_period[0] != '0) begin
                state_nxt = S_SCAN;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan     = 1'b1;
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        if (scan_cnt_r == SCAN_LAST) begin
          scan_cnt_nxt = '0;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op    = dttq_pkg::OP_INSERT;
        count_nxt = count_r + CNT_W'(1);
        if (func_r == dttq_pkg::FUNC_ADD) begin
          res_pos_nxt = CNT_W'(pos_f);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    ins_id_r    <= ins_id_nxt;
    ins_dly_r   <= ins_dly_nxt;
    ins_per_r   <= ins_per_nxt;
    res_fired_r <= res_fired_nxt;
    res_task_r  <= res_task_nxt;
    res_full_r  <= res_full_nxt;
    res_pos_r   <= res_pos_nxt;
    if (load_out) begin
      out_fired_r <= res_fired_r;
      out_task_r  <= res_task_r;
      out_full_r  <= res_full_r;
      out_pos_r   <= res_pos_r;
      out_total_r <= count_r;
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.fired        = out_fired_r;
  assign out_chan.fired_task   = out_task_r;
  assign out_chan.add_full     = out_full_r;
  assign out_chan.add_position = out_pos_r;
  assign out_chan.entry_total  = out_total_r;

endmodule

// ----- src/dttq_checker.sv -----
// ----------------------------------------------------------------------------
// dttq_checker
// Port-level checks of the timer queue result channel, bound to the top.
// ----------------------------------------------------------------------------
module dttq_checker #(
  parameter int QUEUE_DEPTH = dttq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_W        = dttq_pkg::TASK_ID_BITS_DEF,
  parameter int CNT_W       = 5
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             fired,
  input logic [ID_W-1:0]  fired_task,
  input logic             add_full,
  input logic [CNT_W-1:0] add_position,
  input logic [CNT_W-1:0] entry_total
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fired) && $stable(fired_task)
      && $stable(add_full) && $stable(add_position) && $stable(entry_total))
    else $error("result changed while stalled");

  a_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && add_full |-> add_position == CNT_FULL && entry_total == CNT_FULL)
    else $error("rejected add without full queue");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(fired && add_full))
    else $error("fire and full in one result");

  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fired |-> fired_task == '0)
    else $error("task id without fire");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_total <= CNT_FULL)
    else $error("entry total above depth");

endmodule

bind delta_timer_task_queue dttq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .ID_W        (TASK_ID_BITS),
  .CNT_W       ($clog2(QUEUE_DEPTH + 1))
) u_dttq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .fired        (out_chan.fired),
  .fired_task   (out_chan.fired_task),
  .add_full     (out_chan.add_full),
  .add_position (out_chan.add_position),
  .entry_total  (out_chan.entry_total)
);

// ----- verif/delta_timer_task_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_timer_task_queue_test
// Self-checking bench for the delta-list timer queue. Requests go in over a
// valid/ready channel, and a local model of the queue predicts each result.
// Every result is checked field by field against the oldest prediction. The
// run covers directed corner cases and a full queue, then random traffic
// with idle cycles on both sides, and a long receiver stall that backs up
// the input.
// ----------------------------------------------------------------------------
module delta_timer_task_queue_test;

  localparam logic [dttq_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int DEPTH = dttq_pkg::QUEUE_DEPTH_DEF;

  typedef struct {
    logic       fired;
    logic [7:0] fired_task;
    logic       add_full;
    logic [4:0] add_position;
    logic [4:0] entry_total;
  } outcome_t;

  logic clk;
  logic rst_n;

  dttq_in_if  in_chan ();
  dttq_out_if out_chan ();

  delta_timer_task_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [31:0] slot_delta  [DEPTH];
  logic [31:0] slot_period [DEPTH];
  logic [7:0]  slot_task   [DEPTH];
  int          queued;

  outcome_t expected_results[$];
  int       mismatch_count;
  int       request_total;
  int       big_delay_adds;
  int       hold_request;
  int       hold_left;
  bit       steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [4:0] place_task(logic [7:0] id, logic [31:0] dly,
                                            logic [31:0] per);
    logic [31:0] cum;
    logic [31:0] before_sum;
    logic [31:0] new_delta;
    int          pos;
    bit          found;
    cum = '0;
    before_sum = '0;
    pos = queued;
    found = 1'b0;
    if (queued >= DEPTH) return 5'(DEPTH);
    for (int i = 0; i < queued; i++) begin
      if (!found) begin
        before_sum = cum;
        cum = cum + slot_delta[i];
        if (dly < cum) begin
          pos = i;
          found = 1'b1;
        end
      end
    end
    if (!found) before_sum = cum;
    new_delta = dly - before_sum;
    for (int i = queued; i > pos; i--) begin
      slot_delta[i]  = slot_delta[i-1];
      slot_period[i] = slot_period[i-1];
      slot_task[i]   = slot_task[i-1];
    end
    slot_delta[pos]  = new_delta;
    slot_period[pos] = per;
    slot_task[pos]   = id;
    if (pos < queued) slot_delta[pos+1] = slot_delta[pos+1] - new_delta;
    queued++;
    return 5'(pos);
  endfunction

  function automatic outcome_t predict_outcome(logic [dttq_pkg::FUNC_W-1:0] func,
                                               logic [7:0] id, logic [31:0] dly,
                                               logic [31:0] per);
    outcome_t    res;
    logic [7:0]  head_task;
    logic [31:0] head_period;
    res = '{default: '0};
    case (func)
      dttq_pkg::FUNC_TICK: begin
        if (queued > 0 && slot_delta[0] != 0) slot_delta[0] = slot_delta[0] - 1;
      end
      dttq_pkg::FUNC_ADD: begin
        res.add_position = place_task(id, dly, per);
        res.add_full = (res.add_position == 5'(DEPTH));
      end
      dttq_pkg::FUNC_DISPATCH: begin
        if (queued > 0 && slot_delta[0] == 0) begin
          head_task = slot_task[0];
          head_period = slot_period[0];
          res.fired = 1'b1;
          res.fired_task = head_task;
          for (int i = 1; i < queued; i++) begin
            slot_delta[i-1]  = slot_delta[i];
            slot_period[i-1] = slot_period[i];
            slot_task[i-1]   = slot_task[i];
          end
          queued--;
          if (head_period != 0) void'(place_task(head_task, head_period, head_period));
        end
      end
      default: ;
    endcase
    res.entry_total = 5'(queued);
    return res;
  endfunction

  function automatic int periodic_count();
    int n;
    n = 0;
    for (int i = 0; i < queued; i++) if (slot_period[i] != 0) n++;
    return n;
  endfunction

  task automatic send_request(logic [dttq_pkg::FUNC_W-1:0] func, logic [7:0] id,
                              logic [31:0] dly, logic [31:0] per);
    in_chan.valid   <= 1'b1;
    in_chan.func    <= func;
    in_chan.task_id <= id;
    in_chan.delay   <= dly;
    in_chan.period  <= per;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(predict_outcome(func, id, dly, per));
    if (func != FUNC_UNKNOWN) request_total++;
    if (!steady && $urandom_range(99) < 13) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random_add();
    logic [31:0] dly;
    logic [31:0] per;
    dly = $urandom_range(0, 24);
    per = '0;
    if (big_delay_adds < 4 && $urandom_range(99) < 3) begin
      dly = $urandom;
      big_delay_adds++;
    end
    if (periodic_count() < 3 && $urandom_range(99) < 25)
      per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 30);
    send_request(dttq_pkg::FUNC_ADD, 8'($urandom), dly, per);
  endtask

  task automatic send_noise();
    logic [dttq_pkg::FUNC_W-1:0] func;
    case ($urandom_range(2))
      0:       func = dttq_pkg::FUNC_TICK;
      1:       func = dttq_pkg::FUNC_DISPATCH;
      default: func = FUNC_UNKNOWN;
    endcase
    send_request(func, 8'($urandom), $urandom, $urandom);
  endtask

  task automatic report_field(string name, longint unsigned exp_val,
                              longint unsigned act_val);
    $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    outcome_t exp_res;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual %0h",
                 $time, out_chan.entry_total);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_chan.fired !== exp_res.fired)
          report_field("fired", exp_res.fired, out_chan.fired);
        if (out_chan.fired_task !== exp_res.fired_task)
          report_field("fired_task", exp_res.fired_task, out_chan.fired_task);
        if (out_chan.add_full !== exp_res.add_full)
          report_field("add_full", exp_res.add_full, out_chan.add_full);
        if (out_chan.add_position !== exp_res.add_position)
          report_field("add_position", exp_res.add_position, out_chan.add_position);
        if (out_chan.entry_total !== exp_res.entry_total)
          report_field("entry_total", exp_res.entry_total, out_chan.entry_total);
      end
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic test_corner_cases();
    send_request(dttq_pkg::FUNC_TICK, 8'h00, '0, '0);
    send_request(dttq_pkg::FUNC_DISPATCH, 8'h00, '0, '0);
    send_request(FUNC_UNKNOWN, 8'hFF, '1, '1);
    send_request(dttq_pkg::FUNC_ADD, 8'hFF, 32'd0, 32'd0);
    send_request(dttq_pkg::FUNC_DISPATCH, 8'h00, '0, '0);
    send_request(dttq_pkg::FUNC_ADD, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(dttq_pkg::FUNC_ADD, 8'hA5, 32'd5, 32'd3);
    send_request(dttq_pkg::FUNC_ADD, 8'h5A, 32'd5, 32'd0);
    send_request(dttq_pkg::FUNC_ADD, 8'h3C, 32'd0, 32'd0);
    send_request(dttq_pkg::FUNC_DISPATCH, 8'h00, '0, '0);
    repeat (6) send_request(dttq_pkg::FUNC_TICK, 8'h00, '0, '0);
    send_request(dttq_pkg::FUNC_DISPATCH, 8'h00, '0, '0);
    send_request(dttq_pkg::FUNC_DISPATCH, 8'h00, '0, '0);
    send_request(FUNC_UNKNOWN, 8'h12, 32'h5555_AAAA, 32'hAAAA_5555);
  endtask

  task automatic test_queue_full();
    while (queued < DEPTH)
      send_request(dttq_pkg::FUNC_ADD, 8'($urandom), $urandom_range(0, 40), '0);
    send_request(dttq_pkg::FUNC_ADD, 8'hC3, 32'd1, 32'd0);
    send_request(dttq_pkg::FUNC_ADD, 8'h7E, 32'd0, 32'd7);
  endtask

  task automatic test_random_traffic();
    int kind;
    while (request_total < 900) begin
      steady = (request_total >= 350 && request_total < 500);
      kind = $urandom_range(99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 4)) send_random_add();
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 8))
          send_request(dttq_pkg::FUNC_TICK, 8'($urandom), '0, '0);
        repeat ($urandom_range(1, 3))
          send_request(dttq_pkg::FUNC_DISPATCH, 8'($urandom), '0, '0);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 3))
          send_request(dttq_pkg::FUNC_DISPATCH, 8'($urandom), '0, '0);
      end else if (kind < 91) begin
        while (queued < DEPTH)
          send_request(dttq_pkg::FUNC_ADD, 8'($urandom), $urandom_range(0, 30), '0);
        send_random_add();
      end else begin
        send_noise();
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_request = 250;
    repeat (40) begin
      case ($urandom_range(2))
        0:       send_request(dttq_pkg::FUNC_TICK, 8'($urandom), '0, '0);
        1:       send_request(dttq_pkg::FUNC_DISPATCH, 8'($urandom), '0, '0);
        default: send_random_add();
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = dttq_pkg::FUNC_TICK;
    in_chan.task_id = '0;
    in_chan.delay = '0;
    in_chan.period = '0;
    queued = 0;
    mismatch_count = 0;
    request_total = 0;
    big_delay_adds = 0;
    hold_request = 0;
    hold_left = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_queue_full();
    test_random_traffic();
    test_output_backpressure();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dttq_pkg.sv
src/dttq_in_if.sv
src/dttq_out_if.sv
src/dttq_cell.sv
src/delta_timer_task_queue.sv
src/dttq_checker.sv
verif/delta_timer_task_queue_test.sv
